FILE: rtl/core/sweb_pkg.sv
// Package: shared constants, command and status codes, and controller/datapath structs.
`default_nettype none
package sweb_pkg;

    // Sizes of the stores and fields.
    localparam int TABLE_ROWS = 1024;
    localparam int MAX_ELEMS  = 64;
    localparam int MAX_BATCH  = 256;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int TROW_W  = 10;
    localparam int COL_W   = 6;
    localparam int BROW_W  = 8;
    localparam int ELEM_W  = 7;
    localparam int BATCH_W = 9;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TBL_AW  = TROW_W + COL_W;
    localparam int ACC_AW  = BROW_W + COL_W;
    localparam int PROD_W  = 2 * DATA_WIDTH;

    // Q16.16 constants.
    localparam logic signed [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] VAL_MAX_W =
        {{(DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [PROD_W-1:0] VAL_MIN_W = ~VAL_MAX_W;

    // Commands of an input transaction.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_ENTRY = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE  = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RUN,
        S_DRAIN,
        S_RDWAIT,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;
        logic             do_load;
        logic             do_start;
        logic             entry_begin;
        logic             issue;
        logic [COL_W-1:0] col;
        logic             rd_req;
        logic             out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd             cmd;
        logic             bad;
        logic [COL_W-1:0] last_col;
        logic             pipe_busy;
        logic             out_full;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: rtl/core/sweb_in_if.sv
// Interface: input transaction channel.
`default_nettype none
interface sweb_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             command;
    logic [sweb_pkg::TROW_W-1:0]            table_row;
    logic [sweb_pkg::COL_W-1:0]             column;
    logic [sweb_pkg::BROW_W-1:0]            batch_row;
    logic signed [sweb_pkg::DATA_WIDTH-1:0] table_word;
    logic signed [sweb_pkg::DATA_WIDTH-1:0] weight;

    modport source (output valid, command, table_row, column, batch_row, table_word, weight,
                    input ready);
    modport sink (input valid, command, table_row, column, batch_row, table_word, weight,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sweb_out_if.sv
// Interface: result transaction channel.
`default_nettype none
interface sweb_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sweb_pkg::DATA_WIDTH-1:0] result_value;
    logic [sweb_pkg::STAT_W-1:0]            status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sweb_cfg_if.sv
// Interface: configuration write channel.
`default_nettype none
interface sweb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sweb_pkg::CFG_IDX_W-1:0]    index;
    logic [sweb_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sweb_ctrl.sv
// Controller: sequences one transaction at a time through the datapath.
`default_nettype none
module sweb_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sweb_pkg::t_dp_stat i_stat,
    output sweb_pkg::t_dp_cmd       o_cmd
);
    import sweb_pkg::*;

    t_state           r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;

    // State and column counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_col = '0;
                if (i_stat.bad) n_state = S_FINISH;
                else if (i_stat.cmd == CMD_ENTRY) n_state = S_RUN;
                else if (i_stat.cmd == CMD_READ) n_state = S_RDWAIT;
                else n_state = S_FINISH;
            end
            S_RUN: begin
                n_col = r_col + COL_W'(1);
                if (r_col == i_stat.last_col) begin
                    n_col   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = S_FINISH;
            end
            S_RDWAIT: n_state = S_FINISH;
            // The result is held back until the output register is free.
            S_FINISH: begin
                if (!i_stat.out_full) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.col  = r_col;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_LOAD:  o_cmd.do_load     = !i_stat.bad;
                    CMD_START: o_cmd.do_start    = 1'b1;
                    CMD_ENTRY: o_cmd.entry_begin = !i_stat.bad;
                    CMD_READ:  o_cmd.rd_req      = !i_stat.bad;
                    default:   o_cmd.do_start    = 1'b0;
                endcase
            end
            S_RUN:    o_cmd.issue    = 1'b1;
            S_FINISH: o_cmd.out_load = !i_stat.out_full;
            default:  o_cmd.issue    = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/sweb_datapath.sv
// Datapath: configuration, table and accumulator memories, multiply-accumulate pipeline.
`default_nettype none
module sweb_datapath (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire sweb_pkg::t_dp_cmd                      i_cmd,
    output sweb_pkg::t_dp_stat                          o_stat,
    input  wire logic                                   i_cfg_we,
    input  wire logic [sweb_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [sweb_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic [1:0]                             i_command,
    input  wire logic [sweb_pkg::TROW_W-1:0]            i_table_row,
    input  wire logic [sweb_pkg::COL_W-1:0]             i_column,
    input  wire logic [sweb_pkg::BROW_W-1:0]            i_batch_row,
    input  wire logic signed [sweb_pkg::DATA_WIDTH-1:0] i_table_word,
    input  wire logic signed [sweb_pkg::DATA_WIDTH-1:0] i_weight,
    input  wire logic                                   i_out_ready,
    output logic                                        o_out_valid,
    output logic signed [sweb_pkg::DATA_WIDTH-1:0]      o_result_value,
    output logic [sweb_pkg::STAT_W-1:0]                 o_status
);
    import sweb_pkg::*;

    // Configuration registers.
    logic                 r_use_weights;
    logic [TROW_W-1:0]    r_default_row;
    logic [ELEM_W-1:0]    r_elem_size;
    logic [BATCH_W-1:0]   r_batch_size;

    // Captured transaction.
    t_cmd                         r_cmd;
    logic [TROW_W-1:0]            r_trow;
    logic [COL_W-1:0]             r_col;
    logic [BROW_W-1:0]            r_brow;
    logic signed [DATA_WIDTH-1:0] r_word;
    logic signed [DATA_WIDTH-1:0] r_wgt;

    // Batch bookkeeping.
    logic [MAX_BATCH-1:0] r_touched;
    logic                 r_last_valid;
    logic [BROW_W-1:0]    r_last_row;
    logic                 r_clr;
    logic                 r_sat;
    logic                 r_rd_acc;

    // Memories and their registered read data.
    logic signed [DATA_WIDTH-1:0] r_tbl_mem [2**TBL_AW];
    logic signed [DATA_WIDTH-1:0] r_acc_mem [2**ACC_AW];
    logic signed [DATA_WIDTH-1:0] r_tbl_q;
    logic signed [DATA_WIDTH-1:0] r_acc_q;
    logic [TBL_AW-1:0]            tbl_raddr;
    logic [ACC_AW-1:0]            acc_raddr;

    // Pipeline.
    logic                         r_v1, r_v2, r_v3;
    logic [COL_W-1:0]             r_c1, r_c2, r_c3;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [DATA_WIDTH-1:0] r_acc2, r_acc3, r_prodr;
    logic                         r_psat3;

    // Output register.
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_value;
    logic [STAT_W-1:0]            r_out_status;

    logic [ELEM_W-1:0]            ne;
    logic [BATCH_W-1:0]           nb;
    logic                         bad;
    logic signed [DATA_WIDTH-1:0] w_eff;
    logic signed [PROD_W-1:0]     rnd_full;
    logic                         rnd_sat;
    logic signed [DATA_WIDTH-1:0] rnd_val;
    logic signed [DATA_WIDTH:0]   sum_full;
    logic                         sum_sat;
    logic signed [DATA_WIDTH-1:0] sum_val;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_weights <= 1'b0;
            r_default_row <= '0;
            r_elem_size   <= ELEM_W'(MAX_ELEMS);
            r_batch_size  <= BATCH_W'(MAX_BATCH);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_USE_WEIGHTS: r_use_weights <= i_cfg_data[0];
                REG_DEFAULT_ROW: r_default_row <= i_cfg_data[TROW_W-1:0];
                REG_ELEM_SIZE:   r_elem_size   <= i_cfg_data[ELEM_W-1:0];
                REG_BATCH_SIZE:  r_batch_size  <= i_cfg_data[BATCH_W-1:0];
                default:         r_use_weights <= r_use_weights;
            endcase
        end
    end

    // Effective sizes, clamped to the supported range.
    always_comb begin
        if (r_elem_size == '0) ne = ELEM_W'(1);
        else if (32'(r_elem_size) > MAX_ELEMS) ne = ELEM_W'(MAX_ELEMS);
        else ne = r_elem_size;
        if (r_batch_size == '0) nb = BATCH_W'(1);
        else if (32'(r_batch_size) > MAX_BATCH) nb = BATCH_W'(MAX_BATCH);
        else nb = r_batch_size;
    end

    // Range checks of the captured transaction.
    always_comb begin
        case (r_cmd)
            CMD_LOAD:  bad = (32'(r_trow) >= TABLE_ROWS) || (32'(r_col) >= MAX_ELEMS);
            CMD_ENTRY: bad = ({1'b0, r_brow} >= nb) || (32'(r_trow) >= TABLE_ROWS);
            CMD_READ:  bad = ({1'b0, r_brow} >= nb) || ({1'b0, r_col} >= ne) ||
                             (!r_touched[r_brow] && (32'(r_default_row) >= TABLE_ROWS));
            default:   bad = 1'b0;
        endcase
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.bad       = bad;
    assign o_stat.last_col  = COL_W'(ne - ELEM_W'(1));
    assign o_stat.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_stat.out_full  = r_out_valid;

    // Capture of the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= CMD_START;
        end else if (i_cmd.capture) begin
            r_cmd <= t_cmd'(i_command);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_trow <= i_table_row;
            r_col  <= i_column;
            r_brow <= i_batch_row;
            r_word <= i_table_word;
            r_wgt  <= i_weight;
        end
    end

    // Touched marks and the previous batch row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched    <= '0;
            r_last_valid <= 1'b0;
            r_last_row   <= '0;
        end else if (i_cmd.do_start) begin
            r_touched    <= '0;
            r_last_valid <= 1'b0;
            r_last_row   <= '0;
        end else if (i_cmd.entry_begin) begin
            r_touched[r_brow] <= 1'b1;
            r_last_valid      <= 1'b1;
            r_last_row        <= r_brow;
        end
    end

    // A change of batch row starts the row from zero; saturation is sticky per entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.entry_begin) begin
            r_clr <= !r_last_valid || (r_brow != r_last_row);
        end
        if (i_cmd.rd_req) begin
            r_rd_acc <= r_touched[r_brow];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.entry_begin) begin
            r_sat <= 1'b0;
        end else if (r_v3 && (r_psat3 || sum_sat)) begin
            r_sat <= 1'b1;
        end
    end

    // Read addresses: column walk during an entry, otherwise the read transaction.
    assign tbl_raddr = i_cmd.issue ? {r_trow, i_cmd.col} : {r_default_row, r_col};
    assign acc_raddr = i_cmd.issue ? {r_brow, i_cmd.col} : {r_brow, r_col};

    // Embedding table memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_load) begin
            r_tbl_mem[{r_trow, r_col}] <= r_word;
        end
        r_tbl_q <= r_tbl_mem[tbl_raddr];
    end

    // Accumulator memory.
    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            r_acc_mem[{r_brow, r_c3}] <= sum_val;
        end
        r_acc_q <= r_acc_mem[acc_raddr];
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign w_eff = r_use_weights ? r_wgt : ONE_Q;

    // Product rounded to nearest, ties upward, then saturated.
    always_comb begin
        rnd_full = (r_prod + ROUND_HALF) >>> FRAC_BITS;
        rnd_sat  = (rnd_full > VAL_MAX_W) || (rnd_full < VAL_MIN_W);
        if (rnd_full > VAL_MAX_W) rnd_val = VAL_MAX_W[DATA_WIDTH-1:0];
        else if (rnd_full < VAL_MIN_W) rnd_val = VAL_MIN_W[DATA_WIDTH-1:0];
        else rnd_val = rnd_full[DATA_WIDTH-1:0];
    end

    // Saturating accumulation.
    always_comb begin
        sum_full = (r_clr ? '0 : {r_acc3[DATA_WIDTH-1], r_acc3}) +
                   {r_prodr[DATA_WIDTH-1], r_prodr};
        sum_sat  = sum_full[DATA_WIDTH] != sum_full[DATA_WIDTH-1];
        if (!sum_sat) sum_val = sum_full[DATA_WIDTH-1:0];
        else if (sum_full[DATA_WIDTH]) sum_val = VAL_MIN_W[DATA_WIDTH-1:0];
        else sum_val = VAL_MAX_W[DATA_WIDTH-1:0];
    end

    // Pipeline payload: multiply, then round, then add and write back.
    always_ff @(posedge i_clk) begin
        r_c1    <= i_cmd.col;
        r_c2    <= r_c1;
        r_c3    <= r_c2;
        r_prod  <= r_tbl_q * w_eff;
        r_acc2  <= r_acc_q;
        r_acc3  <= r_acc2;
        r_prodr <= rnd_val;
        r_psat3 <= rnd_sat;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_cmd == CMD_READ && !bad) r_out_value <= r_rd_acc ? r_acc_q : r_tbl_q;
            else r_out_value <= '0;
            if (bad) r_out_status <= STAT_RANGE;
            else if (r_cmd == CMD_ENTRY && r_sat) r_out_status <= STAT_SAT;
            else r_out_status <= STAT_OK;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

`ifndef SYNTHESIS
    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid) else $error("result overwritten");

    // Loading a result makes it visible on the next cycle.
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid) else $error("result not presented");

    // Columns are only walked for a sparse entry.
    a_issue_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (r_cmd == CMD_ENTRY)) else $error("column issued for wrong command");

    // A new transaction only enters an empty pipeline.
    a_capture_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> !(r_v1 || r_v2 || r_v3)) else $error("capture while busy");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/sparse_weighted_embedding_sum_core.sv
// Top level: weighted embedding-bag sum core with table load, batch start, entry and read.
`default_nettype none
// One transaction is handled at a time. A sparse entry's time from acceptance to result is set
// by the column walk: one table read, one 32x32 multiply and one accumulator read-modify-write
// per column through a four-stage pipeline that drains before the result. Results wait in an
// output register; the next transaction is accepted while a result waits there, and its own
// result is held back until that register has been taken.
// Configuration writes are always accepted and must only be issued while the core is idle.
module sparse_weighted_embedding_sum_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sweb_in_if.sink     i_in,
    sweb_out_if.source  o_out,
    sweb_cfg_if.sink    i_cfg
);
    import sweb_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    // Configuration writes never stall.
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    sweb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sweb_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_idx      (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_command      (i_in.command),
        .i_table_row    (i_in.table_row),
        .i_column       (i_in.column),
        .i_batch_row    (i_in.batch_row),
        .i_table_word   (i_in.table_word),
        .i_weight       (i_in.weight),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_status       (o_out.status)
    );

endmodule
`default_nettype wire
